// ===== hw/rtl/matrix3x3_inverse_top_assert.svh =====
// Assertion macros shared by the RTL files.
`ifndef MATRIX3X3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3X3_INVERSE_TOP_ASSERT_SVH

// Checked only while out of reset.
`define M3INV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define M3INV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/m3inv_pkg.sv =====
package m3inv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int DW         = DATA_WIDTH;
    localparam int PW         = 2 * DW;      // element product
    localparam int CW         = 2 * DW + 1;  // cofactor
    localparam int DETW       = 3 * DW + 1;  // determinant

    // cofactor k = m[a]*m[b] - m[c]*m[d], row-major element index
    localparam int COF_IDX [9][4] = '{
        '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } in_word_t;

    typedef struct packed {
        logic signed [DW-1:0] inv00;
        logic signed [DW-1:0] inv01;
        logic signed [DW-1:0] inv02;
        logic signed [DW-1:0] inv10;
        logic signed [DW-1:0] inv11;
        logic signed [DW-1:0] inv12;
        logic signed [DW-1:0] inv20;
        logic signed [DW-1:0] inv21;
        logic signed [DW-1:0] inv22;
        logic                 singular;
        logic                 saturated;
    } out_word_t;

    // adjugate plus first row, cofactor stage to determinant stage
    typedef struct packed {
        logic [8:0][CW-1:0] adj;
        logic [2:0][DW-1:0] row0;
    } cof_word_t;

    // adjugate plus determinant, into the divider
    typedef struct packed {
        logic [8:0][CW-1:0] adj;
        logic [DETW-1:0]    det;
    } det_word_t;

endpackage

// ===== hw/rtl/m3inv_cofactor.sv =====
module m3inv_cofactor
    import m3inv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output cof_word_t out_data
);

    localparam int NS = 2;

    logic signed [DW-1:0] m [9];
    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic signed [PW-1:0] prod_reg [9][2];
    logic [2:0][DW-1:0]   row0_reg [NS];
    logic [8:0][CW-1:0]   adj_reg;

    assign m[0] = in_data.m00;
    assign m[1] = in_data.m01;
    assign m[2] = in_data.m02;
    assign m[3] = in_data.m10;
    assign m[4] = in_data.m11;
    assign m[5] = in_data.m12;
    assign m[6] = in_data.m20;
    assign m[7] = in_data.m21;
    assign m[8] = in_data.m22;

    // stall chain: a stage moves when empty or when the next one moves
    assign en[NS] = out_ready;
    for (genvar s = 0; s < NS; s++) begin : g_en
        assign en[s] = !v_reg[s] || en[s+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int k = 0; k < 9; k++) begin
                prod_reg[k][0] <= m[COF_IDX[k][0]] * m[COF_IDX[k][1]];
                prod_reg[k][1] <= m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
            end
            row0_reg[0] <= {in_data.m00, in_data.m01, in_data.m02};
        end
        if (en[1]) begin
            for (int k = 0; k < 9; k++) begin
                adj_reg[k] <= CW'(prod_reg[k][0]) - CW'(prod_reg[k][1]);
            end
            row0_reg[1] <= row0_reg[0];
        end
    end

    assign in_ready      = en[0];
    assign out_valid     = v_reg[NS-1];
    assign out_data.adj  = adj_reg;
    assign out_data.row0 = row0_reg[NS-1];

endmodule

// ===== hw/rtl/m3inv_det.sv =====
module m3inv_det
    import m3inv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  cof_word_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output det_word_t out_data
);

    localparam int NS = 3;
    localparam int HW = CW - DW;  // signed upper slice of a cofactor

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic [8:0][CW-1:0] adj_reg [NS];
    logic signed [2*DW:0]      plo_reg [3];
    logic signed [DW+HW-1:0]   phi_reg [3];
    logic signed [DETW-1:0]    term_reg [3];
    logic signed [DETW-1:0]    det_reg;

    assign en[NS] = out_ready;
    for (genvar s = 0; s < NS; s++) begin : g_en
        assign en[s] = !v_reg[s] || en[s+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++) begin
                if (en[s]) v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // row 0 times cofactors 0, 3, 6; each wide product split in two halves
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int j = 0; j < 3; j++) begin
                plo_reg[j] <= $signed(in_data.row0[2-j])
                            * $signed({1'b0, in_data.adj[3*j][DW-1:0]});
                phi_reg[j] <= $signed(in_data.row0[2-j])
                            * $signed(in_data.adj[3*j][CW-1:DW]);
            end
            adj_reg[0] <= in_data.adj;
        end
        if (en[1]) begin
            for (int j = 0; j < 3; j++) begin
                term_reg[j] <= (DETW'(phi_reg[j]) <<< DW) + DETW'(plo_reg[j]);
            end
            adj_reg[1] <= adj_reg[0];
        end
        if (en[2]) begin
            det_reg    <= term_reg[0] + term_reg[1] + term_reg[2];
            adj_reg[2] <= adj_reg[1];
        end
    end

    assign in_ready     = en[0];
    assign out_valid    = v_reg[NS-1];
    assign out_data.adj = adj_reg[NS-1];
    assign out_data.det = det_reg;

endmodule

// ===== hw/rtl/m3inv_divider.sv =====
module m3inv_divider
    import m3inv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  det_word_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

`include "matrix3x3_inverse_top_assert.svh"

    localparam int NUMW = CW + 2 * FRAC_BITS;
    localparam int DENW = DETW + DW;
    localparam int RW   = (NUMW > DENW) ? NUMW : DENW;
    localparam int NS   = DW + 2;  // prep, one stage per quotient bit, output

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic [RW-1:0]   rem_reg  [DW+1][9];
    logic [DW-1:0]   q_reg    [DW+1][9];
    logic [8:0]      neg_reg  [DW+1];
    logic [8:0]      ovf_reg  [DW+1];
    logic            sing_reg [DW+1];
    logic [DETW-1:0] absd_reg [DW+1];
    out_word_t       out_reg;
    out_word_t       out_next;

    logic signed [DETW-1:0] det_s;
    logic [DETW-1:0]        absd;
    logic [RW-1:0]          dshift;
    logic signed [CW-1:0]   cof_s   [9];
    logic [CW-1:0]          absc    [9];
    logic [RW-1:0]          nume    [9];

    assign en[NS] = out_ready;
    for (genvar s = 0; s < NS; s++) begin : g_en
        assign en[s] = !v_reg[s] || en[s+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++) begin
                if (en[s]) v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // prep: magnitudes, signs, scaled numerators, quotient overflow test
    always_comb begin
        det_s  = $signed(in_data.det);
        absd   = det_s[DETW-1] ? DETW'(-det_s) : DETW'(det_s);
        dshift = RW'(absd) << DW;
        for (int l = 0; l < 9; l++) begin
            cof_s[l] = $signed(in_data.adj[l]);
            absc[l]  = cof_s[l][CW-1] ? CW'(-cof_s[l]) : CW'(cof_s[l]);
            nume[l]  = RW'(absc[l]) << (2 * FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int l = 0; l < 9; l++) begin
                rem_reg[0][l] <= nume[l];
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= cof_s[l][CW-1] ^ det_s[DETW-1];
                ovf_reg[0][l] <= nume[l] >= dshift;
            end
            sing_reg[0] <= (in_data.det == '0);
            absd_reg[0] <= absd;
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    for (genvar k = 1; k <= DW; k++) begin : g_div
        localparam int B = DW - k;
        logic [RW-1:0] dsh;
        assign dsh = RW'(absd_reg[k-1]) << B;
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                for (int l = 0; l < 9; l++) begin
                    if (rem_reg[k-1][l] >= dsh) begin
                        rem_reg[k][l] <= rem_reg[k-1][l] - dsh;
                        q_reg[k][l]   <= q_reg[k-1][l] | (DW'(1) << B);
                    end else begin
                        rem_reg[k][l] <= rem_reg[k-1][l];
                        q_reg[k][l]   <= q_reg[k-1][l];
                    end
                end
                neg_reg[k]  <= neg_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                sing_reg[k] <= sing_reg[k-1];
                absd_reg[k] <= absd_reg[k-1];
            end
        end
    end

    // clamp, apply sign, zero out a singular matrix
    always_comb begin
        logic [DW-1:0] lim;
        logic [DW-1:0] mag;
        logic [DW-1:0] res [9];
        logic          sat;
        sat = 1'b0;
        for (int l = 0; l < 9; l++) begin
            lim = neg_reg[DW][l] ? (DW'(1) << (DW - 1)) : ((DW'(1) << (DW - 1)) - DW'(1));
            if (ovf_reg[DW][l] || (q_reg[DW][l] > lim)) begin
                mag = lim;
                sat = 1'b1;
            end else begin
                mag = q_reg[DW][l];
            end
            res[l] = neg_reg[DW][l] ? (~mag + DW'(1)) : mag;
            if (sing_reg[DW]) res[l] = '0;
        end
        out_next.inv00     = res[0];
        out_next.inv01     = res[1];
        out_next.inv02     = res[2];
        out_next.inv10     = res[3];
        out_next.inv11     = res[4];
        out_next.inv12     = res[5];
        out_next.inv20     = res[6];
        out_next.inv21     = res[7];
        out_next.inv22     = res[8];
        out_next.singular  = sing_reg[DW];
        out_next.saturated = sat && !sing_reg[DW];
    end

    always_ff @(posedge aclk) begin
        if (en[NS-1]) out_reg <= out_next;
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = out_reg;

    `M3INV_ASSERT(a_div_drain, out_ready |-> in_ready, "divider stalls with sink ready")
    `M3INV_ASSERT(a_div_hold, (v_reg[0] && !en[0]) |=> (v_reg[0] && $stable(absd_reg[0])), "prep stage lost a held word")
    `M3INV_ASSERT_ALWAYS(a_div_reset, $past(!aresetn) |-> (v_reg == '0), "stage valid set after reset")

endmodule

// ===== hw/rtl/matrix3x3_inverse_top.sv =====
// channel | direction | handshake          | word
// s_      | in        | s_valid / s_ready  | in_word_t: m00 .. m22, Q16.16
// m_      | out       | m_valid / m_ready  | out_word_t: inv00 .. inv22, singular, saturated
//
// Path: cofactor stages, determinant stages, then the divider (prep, quotient bits, output).
// Throughput: one matrix per cycle while m_ready holds; the 32 stage restoring divider sets the depth.
// Reset: aresetn, synchronous, active low, clears all stage valid bits.
// Stalls: each stage holds while full and blocked; empty stages keep filling,
// so s_ready stays high until every stage holds a word.
module matrix3x3_inverse_top
    import m3inv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

`include "matrix3x3_inverse_top_assert.svh"

    // cofactor -> determinant
    logic      cof_valid;
    logic      cof_ready;
    cof_word_t cof_data;
    // determinant -> divider
    logic      det_valid;
    logic      det_ready;
    det_word_t det_data;

    // nine 2x2 cofactors: products, then differences
    m3inv_cofactor u_cofactor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (cof_valid),
        .out_ready (cof_ready),
        .out_data  (cof_data)
    );

    // expansion along row 0, split wide products
    m3inv_det u_det (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cof_valid),
        .in_ready  (cof_ready),
        .in_data   (cof_data),
        .out_valid (det_valid),
        .out_ready (det_ready),
        .out_data  (det_data)
    );

    // exact cofactor / det, truncate toward zero, saturate
    m3inv_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (det_valid),
        .in_ready  (det_ready),
        .in_data   (det_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    `M3INV_ASSERT(a_flow, m_ready |-> s_ready, "pipeline blocks input with sink ready")
    `M3INV_ASSERT(a_sing_zero, (m_valid && m_data.singular) |-> (!m_data.saturated && m_data.inv00 == '0 && m_data.inv11 == '0 && m_data.inv22 == '0), "singular word not cleared")
    `M3INV_ASSERT_ALWAYS(a_reset_empty, $past(!aresetn) |-> !m_valid, "result valid right after reset")

endmodule
